FILE: hw/rtl/rst_pkg.sv
// ----------------------------------------------------------------------------
// rst_pkg: shared definitions for the session reference table
// Sizes, command and status codes, word types and the stored entry layout.
// ----------------------------------------------------------------------------
package rst_pkg;

    localparam int BUCKET_BITS  = 4;
    localparam int WAYS         = 4;
    localparam int NUM_BUCKETS  = 1 << BUCKET_BITS;
    localparam int BUCKET_IDX_W = (BUCKET_BITS > 0) ? BUCKET_BITS : 1;
    localparam int WAY_IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [BUCKET_IDX_W-1:0] BUCKET_MASK = BUCKET_IDX_W'(NUM_BUCKETS - 1);

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_REF    = 3'd2,
        CMD_DEREF  = 3'd3,
        CMD_MARK   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_EXISTS = 3'd1,
        STS_NONE   = 3'd2,
        STS_BAD    = 3'd3,
        STS_FULL   = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] session_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ref_count;
        logic        session_ended;
        logic        notify_file_systems;
        logic        fatal_unknown;
    } t_out_word;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] count;
        logic        notify;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

endpackage

FILE: hw/rtl/refcounted_session_table.sv
// ----------------------------------------------------------------------------
// refcounted_session_table: hashed table of reference-counted sessions
// Creates, deletes, references, dereferences and marks session records held
// in a bucket memory with a fixed number of ways per bucket.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid, o_in_stall, i_in_word) carries one command
//   word: a command code and a 64-bit session id. The output channel
//   (o_out_valid, i_out_stall, o_out_word) returns exactly one result word
//   per command, in order.
//   For each command the bucket row is first read from the record memory
//   into r_rd_row; then all ways are compared in parallel, the row is
//   written back and the result word is registered.
//   A new command word is not taken until the previous one has been
//   written back; o_in_stall is high while a command executes.
//   The result sits in an output register, so the next command is taken
//   while that result still waits. If the receiver keeps stalling, the
//   following command waits in ST_EXEC and o_in_stall stays high.
//   Reset clears all valid bits at once, so every bucket is empty; the
//   record memory needs no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_session_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rst_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rst_pkg::t_out_word  o_out_word
);

    rst_pkg::t_row  r_mem [rst_pkg::NUM_BUCKETS];
    rst_pkg::t_row  r_rd_row;
    rst_pkg::t_row  n_row;

    logic [rst_pkg::WAYS-1:0] r_valid [rst_pkg::NUM_BUCKETS];
    logic [rst_pkg::WAYS-1:0] n_valid_row;

    rst_pkg::t_state r_state, n_state;

    logic [2:0]                       r_cmd;
    logic [63:0]                      r_id;
    logic [rst_pkg::BUCKET_IDX_W-1:0] r_bucket;
    logic [rst_pkg::BUCKET_IDX_W-1:0] in_bucket;

    logic               r_out_valid;
    rst_pkg::t_out_word r_out_word, n_out_word;

    logic rd_en, finish, out_free;

    logic [rst_pkg::WAYS-1:0]      hit_vec, free_vec;
    logic                          hit, has_free;
    logic [rst_pkg::WAY_IDX_W-1:0] hit_way, free_way;
    rst_pkg::t_entry               hit_entry;
    logic [31:0]                   dec_count;

    assign in_bucket = rst_pkg::BUCKET_IDX_W'(i_in_word.session_id[rst_pkg::BUCKET_IDX_W-1:0])
                       & rst_pkg::BUCKET_MASK;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rst_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rst_pkg::ST_EXEC;
            end
            rst_pkg::ST_EXEC: begin
                if (out_free) n_state = rst_pkg::ST_IDLE;
            end
            default: n_state = rst_pkg::ST_IDLE;
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        finish     = 1'b0;
        case (r_state)
            rst_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = i_in_valid;
            end
            rst_pkg::ST_EXEC: begin
                finish = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Way match and lowest free way.
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        hit      = 1'b0;
        has_free = 1'b0;
        for (int w = 0; w < rst_pkg::WAYS; w++) begin
            hit_vec[w]  = r_valid[r_bucket][w] && (r_rd_row[w].key == r_id);
            free_vec[w] = !r_valid[r_bucket][w];
        end
        for (int w = rst_pkg::WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit     = 1'b1;
                hit_way = rst_pkg::WAY_IDX_W'(w);
            end
            if (free_vec[w]) begin
                has_free = 1'b1;
                free_way = rst_pkg::WAY_IDX_W'(w);
            end
        end
        hit_entry = r_rd_row[hit_way];
        dec_count = hit_entry.count - 32'd1;
    end

    // Command execution on the bucket row.
    always_comb begin
        n_row       = r_rd_row;
        n_valid_row = r_valid[r_bucket];
        n_out_word  = '0;
        n_out_word.status = rst_pkg::STS_OK;
        case (r_cmd)
            rst_pkg::CMD_CREATE: begin
                if (hit) begin
                    n_out_word.status    = rst_pkg::STS_EXISTS;
                    n_out_word.ref_count = hit_entry.count;
                end else if (has_free) begin
                    n_valid_row[free_way]   = 1'b1;
                    n_row[free_way].key     = r_id;
                    n_row[free_way].count   = '0;
                    n_row[free_way].notify  = 1'b0;
                end else begin
                    n_out_word.status = rst_pkg::STS_FULL;
                end
            end
            rst_pkg::CMD_DELETE: begin
                if (!hit) begin
                    n_out_word.status = rst_pkg::STS_NONE;
                end else if (hit_entry.count != '0) begin
                    n_out_word.status    = rst_pkg::STS_BAD;
                    n_out_word.ref_count = hit_entry.count;
                end else begin
                    n_valid_row[hit_way] = 1'b0;
                end
            end
            rst_pkg::CMD_REF: begin
                if (!hit) begin
                    n_out_word.status = rst_pkg::STS_NONE;
                end else begin
                    // The count saturates rather than wrapping.
                    if (hit_entry.count != '1) n_row[hit_way].count = hit_entry.count + 32'd1;
                    n_out_word.ref_count = n_row[hit_way].count;
                end
            end
            rst_pkg::CMD_DEREF: begin
                if (!hit) begin
                    n_out_word.status        = rst_pkg::STS_NONE;
                    n_out_word.fatal_unknown = 1'b1;
                end else if (hit_entry.count == '0) begin
                    n_out_word.status = rst_pkg::STS_BAD;
                end else begin
                    n_row[hit_way].count = dec_count;
                    n_out_word.ref_count = dec_count;
                    if (dec_count == '0) begin
                        n_valid_row[hit_way]           = 1'b0;
                        n_out_word.session_ended       = 1'b1;
                        n_out_word.notify_file_systems = hit_entry.notify;
                    end
                end
            end
            rst_pkg::CMD_MARK: begin
                if (!hit) begin
                    n_out_word.status = rst_pkg::STS_NONE;
                end else begin
                    n_row[hit_way].notify = 1'b1;
                    n_out_word.ref_count  = hit_entry.count;
                end
            end
            default: begin
                n_out_word.status = rst_pkg::STS_BAD;
            end
        endcase
    end

    // Record memory: one row read and one row written per cycle. The write of
    // one command lands before the next command's read is issued.
    always_ff @(posedge i_clk) begin
        if (finish) r_mem[r_bucket] <= n_row;
        if (rd_en)  r_rd_row <= r_mem[in_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rst_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            for (int b = 0; b < rst_pkg::NUM_BUCKETS; b++) r_valid[b] <= '0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_valid[r_bucket] <= n_valid_row;
                r_out_valid       <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmd    <= i_in_word.command;
            r_id     <= i_in_word.session_id;
            r_bucket <= in_bucket;
        end
        if (finish) r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == rst_pkg::ST_EXEC))
        else $error("accepted word did not start execution");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_out_valid && r_state == rst_pkg::ST_IDLE))
        else $error("finished command did not present a result");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rst_pkg::ST_EXEC) |-> $onehot0(hit_vec))
        else $error("session id live in more than one way");

    a_ended_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.session_ended) |->
        (r_out_word.status == rst_pkg::STS_OK && r_out_word.ref_count == '0))
        else $error("ended session reported with nonzero count");

    a_fatal_is_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.fatal_unknown) |->
        (r_out_word.status == rst_pkg::STS_NONE && !r_out_word.session_ended))
        else $error("fatal flag raised without a missing session");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the session reference table
// Drives command words through the valid/stall input channel, models the
// bucketed session table alongside the block and compares every result word
// in order. A short table of directed commands comes first, then random
// command streams, mostly over a small pool of clustered ids, under several idling
// patterns.
// ----------------------------------------------------------------------------
module tb_top;

    import rst_pkg::*;

    localparam int DEPTH          = NUM_BUCKETS * WAYS;
    localparam int NUM_DIRECTED   = 24;
    localparam int ITEMS_PER_PASS = 235;
    localparam int POOL_SIZE      = 20;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word outcome;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    // Directed words may carry a typed-in result alongside the payload.
    logic       word_typed = 1'b0;
    t_out_word  word_outcome = '0;

    // Shadow copy of the session table.
    logic        sess_live   [DEPTH];
    logic [63:0] sess_key    [DEPTH];
    logic [31:0] sess_count  [DEPTH];
    logic        sess_notify [DEPTH];

    t_out_word   result_q [$];
    t_out_word   predicted;
    int          n_errors    = 0;
    int          idle_cycles = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          hold_reqs   = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    t_stim_row   dir_rows [NUM_DIRECTED];
    logic [63:0] id_pool  [POOL_SIZE];

    refcounted_session_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_out_word outcome(input logic [2:0] status, input logic [31:0] count,
                                          input logic ended, input logic notify,
                                          input logic fatal);
        t_out_word r;
        r.status              = status;
        r.ref_count           = count;
        r.session_ended       = ended;
        r.notify_file_systems = notify;
        r.fatal_unknown       = fatal;
        return r;
    endfunction

    function automatic t_stim_row stim_row(input logic [2:0] command, input logic [63:0] id,
                                           input logic typed, input t_out_word res);
        t_stim_row r;
        r.word.command    = command;
        r.word.session_id = id;
        r.typed           = typed;
        r.outcome         = res;
        return r;
    endfunction

    function automatic void clear_sessions();
        for (int k = 0; k < DEPTH; k++) begin
            sess_live[k]   = 1'b0;
            sess_key[k]    = '0;
            sess_count[k]  = '0;
            sess_notify[k] = 1'b0;
        end
    endfunction

    // Applies one command word to the shadow table and returns its result.
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word r;
        int        base;
        int        hit;
        int        slot;
        logic      placed;
        r      = '0;
        base   = int'(w.session_id[BUCKET_IDX_W-1:0] & BUCKET_MASK) * WAYS;
        hit    = -1;
        placed = 1'b0;
        for (int k = 0; k < WAYS; k++) begin
            if (hit < 0 && sess_live[base+k] && sess_key[base+k] == w.session_id)
                hit = base + k;
        end
        slot = (hit < 0) ? 0 : hit;
        case (w.command)
            CMD_CREATE: begin
                if (hit >= 0) begin
                    r.status    = STS_EXISTS;
                    r.ref_count = sess_count[slot];
                end else begin
                    r.status = STS_FULL;
                    // The lowest free way takes the new session.
                    for (int k = 0; k < WAYS; k++) begin
                        if (!placed && !sess_live[base+k]) begin
                            sess_live[base+k]   = 1'b1;
                            sess_key[base+k]    = w.session_id;
                            sess_count[base+k]  = '0;
                            sess_notify[base+k] = 1'b0;
                            r.status            = STS_OK;
                            placed              = 1'b1;
                        end
                    end
                end
            end
            CMD_DELETE: begin
                if (hit < 0) begin
                    r.status = STS_NONE;
                end else if (sess_count[slot] != 0) begin
                    r.status    = STS_BAD;
                    r.ref_count = sess_count[slot];
                end else begin
                    r.status        = STS_OK;
                    sess_live[slot] = 1'b0;
                end
            end
            CMD_REF: begin
                if (hit < 0) begin
                    r.status = STS_NONE;
                end else begin
                    if (sess_count[slot] != 32'hFFFF_FFFF)
                        sess_count[slot] = sess_count[slot] + 1;
                    r.status    = STS_OK;
                    r.ref_count = sess_count[slot];
                end
            end
            CMD_DEREF: begin
                if (hit < 0) begin
                    r.status        = STS_NONE;
                    r.fatal_unknown = 1'b1;
                end else if (sess_count[slot] == 0) begin
                    r.status = STS_BAD;
                end else begin
                    sess_count[slot] = sess_count[slot] - 1;
                    r.status         = STS_OK;
                    r.ref_count      = sess_count[slot];
                    if (sess_count[slot] == 0) begin
                        sess_live[slot]       = 1'b0;
                        r.session_ended       = 1'b1;
                        r.notify_file_systems = sess_notify[slot];
                    end
                end
            end
            CMD_MARK: begin
                if (hit < 0) begin
                    r.status = STS_NONE;
                end else begin
                    sess_notify[slot] = 1'b1;
                    r.status          = STS_OK;
                    r.ref_count       = sess_count[slot];
                end
            end
            default: r.status = STS_BAD;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_result(input t_out_word want, input t_out_word got);
        check_field("status", want.status, got.status);
        check_field("ref_count", want.ref_count, got.ref_count);
        check_field("session_ended", want.session_ended, got.session_ended);
        check_field("notify_file_systems", want.notify_file_systems,
                    got.notify_file_systems);
        check_field("fatal_unknown", want.fatal_unknown, got.fatal_unknown);
    endtask

    // Offers one word, with random idle gaps beforehand, until it is taken.
    task automatic offer_word(input t_in_word w, input logic typed, input t_out_word res);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_word    <= w;
        word_typed   <= typed;
        word_outcome <= res;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Scoreboard and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result word with none outstanding: %0h", o_out_word);
                    n_errors++;
                end else begin
                    check_result(result_q.pop_front(), o_out_word);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predicted = apply_command(i_in_word);
                result_q.push_back(word_typed ? word_outcome : predicted);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_in_word    w;
        int          pick;
        int          cmd_pick;
        logic [63:0] id;
        int          pass_idle  [4];
        int          pass_stall [4];

        pass_idle  = '{0, 68, 0, 26};
        pass_stall = '{0, 0, 68, 26};
        clear_sessions();

        dir_rows = '{
            stim_row(CMD_DEREF,  64'h0, 1'b1, outcome(STS_NONE, 0, 1'b0, 1'b0, 1'b1)),
            stim_row(CMD_DELETE, '1, 1'b1, outcome(STS_NONE, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_REF,    '1, 1'b1, outcome(STS_NONE, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_MARK,   '1, 1'b1, outcome(STS_NONE, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_CREATE, '1, 1'b1, outcome(STS_OK, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_CREATE, '1, 1'b1, outcome(STS_EXISTS, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_DEREF,  '1, 1'b1, outcome(STS_BAD, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_REF,    '1, 1'b1, outcome(STS_OK, 1, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_DELETE, '1, 1'b1, outcome(STS_BAD, 1, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_MARK,   '1, 1'b1, outcome(STS_OK, 1, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_DEREF,  '1, 1'b1, outcome(STS_OK, 0, 1'b1, 1'b1, 1'b0)),
            stim_row(CMD_CREATE, 64'h0,  1'b0, '0),
            stim_row(CMD_CREATE, 64'h10, 1'b0, '0),
            stim_row(CMD_CREATE, 64'h20, 1'b0, '0),
            stim_row(CMD_CREATE, 64'h30, 1'b0, '0),
            stim_row(CMD_CREATE, 64'h8000_0000_0000_0040, 1'b1,
                     outcome(STS_FULL, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_DELETE, 64'h10, 1'b0, '0),
            stim_row(CMD_CREATE, 64'h40, 1'b0, '0),
            stim_row(CMD_REF,    64'h0,  1'b0, '0),
            stim_row(CMD_DEREF,  64'h0,  1'b0, '0),
            stim_row(3'd5, 64'h5555_5555_AAAA_AAAA, 1'b1,
                     outcome(STS_BAD, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(3'd7, 64'hAAAA_AAAA_5555_5555, 1'b1,
                     outcome(STS_BAD, 0, 1'b0, 1'b0, 1'b0)),
            stim_row(CMD_CREATE, 64'hAAAA_AAAA_5555_5555, 1'b0, '0),
            stim_row(CMD_DELETE, 64'hAAAA_AAAA_5555_5555, 1'b0, '0)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            offer_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].outcome);
        word_typed <= 1'b0;
        wait_drained();

        for (int pass = 0; pass < 4; pass++) begin
            idle_pct  = pass_idle[pass];
            stall_pct = pass_stall[pass];
            // Ids cluster on a few buckets so that buckets fill and ways recycle.
            for (int k = 0; k < POOL_SIZE; k++) begin
                id_pool[k] = {$urandom, $urandom};
                id_pool[k][BUCKET_IDX_W-1:0] = BUCKET_IDX_W'($urandom_range(0, 5));
            end
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                // Hold the receiver off while words keep coming, so the block backs up.
                if (n == 100 && (pass == 0 || pass == 3))
                    hold_reqs <= hold_reqs + 1;
                pick = $urandom_range(99);
                if (pick < 85) begin
                    w.session_id = id_pool[$urandom_range(POOL_SIZE - 1)];
                    cmd_pick     = $urandom_range(99);
                    if (cmd_pick < 25)
                        w.command = CMD_CREATE;
                    else if (cmd_pick < 50)
                        w.command = CMD_REF;
                    else if (cmd_pick < 75)
                        w.command = CMD_DEREF;
                    else if (cmd_pick < 85)
                        w.command = CMD_DELETE;
                    else
                        w.command = CMD_MARK;
                end else if (pick < 95) begin
                    id           = {$urandom, $urandom};
                    w.session_id = id;
                    w.command    = 3'($urandom_range(0, 4));
                end else begin
                    w.session_id = {$urandom, $urandom};
                    w.command    = 3'($urandom_range(5, 7));
                end
                offer_word(w, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
